// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers, clocked and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// prop must hold at every rising edge out of reset
`define ASSERT_AT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// prop must never hold at a rising edge out of reset
`define ASSERT_NEVER_AT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_AT(label, clk, rst_n, prop)
`define ASSERT_NEVER_AT(label, clk, rst_n, prop)

`endif

`endif

// ===== hdl/psq_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sequence store package
// Field widths and action codes shared by the interfaces and the core.
// ---------------------------------------------------------------------------
package psq_pkg;

  localparam int ACT_W   = 3;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 5;

  typedef enum logic [ACT_W-1:0] {
    ACT_APPEND  = 3'd0,
    ACT_DROP    = 3'd1,
    ACT_INSERT  = 3'd2,
    ACT_REMOVE  = 3'd3,
    ACT_READOUT = 3'd4
  } action_e;

endpackage

// ===== hdl/psq_ifs.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sequence store channels
// Valid/ready channels for command items and result items.
// ---------------------------------------------------------------------------

// Command channel
interface psq_in_if;
  logic                               valid;
  logic                               ready;
  logic [psq_pkg::ACT_W-1:0]          action;
  logic signed [psq_pkg::VALUE_W-1:0] value;
  logic [psq_pkg::POS_W-1:0]          position;
  logic                               front_first;

  modport source (output valid, action, value, position, front_first, input ready);
  modport sink   (input valid, action, value, position, front_first, output ready);
endinterface

// Result channel
interface psq_out_if;
  logic                               valid;
  logic                               ready;
  logic                               status;
  logic                               has_data;
  logic signed [psq_pkg::VALUE_W-1:0] data;
  logic                               last;

  modport source (output valid, status, has_data, data, last, input ready);
  modport sink   (input valid, status, has_data, data, last, output ready);
endinterface

// ===== hdl/psq_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module psq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hdl/positional_sequence_store_core.sv =====
// Append, drop and failed actions: result registered in the cycle after the item is taken.
// Insert at p: result registered, entries count-1..p move up in RAM, then value placed.
// Remove at p: result registered, then any entries above p move down in RAM.
// Readout: each element is fetched via the registered RAM read port, then loaded.
// Reset clears count and control; element RAM content is not cleared.
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Positional sequence store
// Ordered list of signed words held in one RAM; insert and remove move
// entries through the RAM one per cycle, readout streams the list out.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module positional_sequence_store_core #(
  parameter int CAPACITY   = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  psq_in_if.sink    in_i,
  psq_out_if.source out_o
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > psq_pkg::POS_W) ? CNT_W : psq_pkg::POS_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SHIFT = 4'b0010,
    S_PLACE = 4'b0100,
    S_READ  = 4'b1000
  } state_e;

  state_e                state_q, state_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [CNT_W-1:0]      left_q, left_d;
  logic [IDX_W-1:0]      rd_q, rd_d;
  logic [IDX_W-1:0]      wr_q, wr_d;
  logic [IDX_W-1:0]      pos_q, pos_d;
  logic [DATA_WIDTH-1:0] val_q, val_d;
  logic                  ins_q, ins_d;
  logic                  up_q, up_d;
  logic                  rd_wait_q, rd_wait_d;

  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic [IDX_W-1:0]      mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata;

  logic                               out_valid_q;
  logic                               out_status_q, out_has_data_q, out_last_q;
  logic [psq_pkg::VALUE_W-1:0]        out_data_q;
  logic                               out_load;
  logic                               ld_status, ld_has_data, ld_last;
  logic [psq_pkg::VALUE_W-1:0]        ld_data;

  logic                  out_free;
  logic                  in_fire;
  logic                  cnt_full, cnt_zero, pos_ok;
  logic [DATA_WIDTH-1:0] value_w;
  logic [CNT_W-1:0]      rm_moves;
  logic [IDX_W-1:0]      shift_nxt;
  logic [IDX_W-1:0]      read_start;

  // element storage
  psq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_elem_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // handshake
  assign out_free   = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == S_IDLE) && out_free;
  assign in_fire    = in_i.valid && in_i.ready;

  // list status and operands
  assign cnt_full   = (count_q == CNT_W'(CAPACITY));
  assign cnt_zero   = (count_q == '0);
  assign pos_ok     = (CMP_W'(in_i.position) < CMP_W'(count_q));
  assign value_w    = DATA_WIDTH'($unsigned(in_i.value));
  assign rm_moves   = count_q - CNT_W'(in_i.position) - CNT_W'(1);
  assign shift_nxt  = ins_q ? (rd_q - IDX_W'(1)) : (rd_q + IDX_W'(1));
  assign read_start = in_i.front_first ? '0 : IDX_W'(count_q - CNT_W'(1));

  // control and RAM access
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    left_d      = left_q;
    rd_d        = rd_q;
    wr_d        = wr_q;
    pos_d       = pos_q;
    val_d       = val_q;
    ins_d       = ins_q;
    up_d        = up_q;
    rd_wait_d   = rd_wait_q;
    mem_we      = 1'b0;
    mem_waddr   = wr_q;
    mem_wdata   = mem_rdata;
    mem_raddr   = rd_q;
    out_load    = 1'b0;
    ld_status   = 1'b1;
    ld_has_data = 1'b0;
    ld_data     = '0;
    ld_last     = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          out_load = 1'b1;
          unique case (in_i.action)
            psq_pkg::ACT_APPEND: begin
              if (!cnt_full) begin
                mem_we    = 1'b1;
                mem_waddr = IDX_W'(count_q);
                mem_wdata = value_w;
                count_d   = count_q + CNT_W'(1);
                ld_status = 1'b0;
              end
            end
            psq_pkg::ACT_DROP: begin
              if (!cnt_zero) begin
                count_d   = count_q - CNT_W'(1);
                ld_status = 1'b0;
              end
            end
            psq_pkg::ACT_INSERT: begin
              if (!cnt_zero && pos_ok && !cnt_full) begin
                // move entries count-1 .. position up by one, then place
                ld_status = 1'b0;
                count_d   = count_q + CNT_W'(1);
                val_d     = value_w;
                pos_d     = IDX_W'(in_i.position);
                ins_d     = 1'b1;
                rd_d      = IDX_W'(count_q - CNT_W'(1));
                mem_raddr = IDX_W'(count_q - CNT_W'(1));
                wr_d      = IDX_W'(count_q);
                left_d    = count_q - CNT_W'(in_i.position);
                state_d   = S_SHIFT;
              end
            end
            psq_pkg::ACT_REMOVE: begin
              if (!cnt_zero && pos_ok) begin
                ld_status = 1'b0;
                count_d   = count_q - CNT_W'(1);
                // move entries above position down by one
                if (rm_moves != '0) begin
                  ins_d     = 1'b0;
                  rd_d      = IDX_W'(in_i.position) + IDX_W'(1);
                  mem_raddr = IDX_W'(in_i.position) + IDX_W'(1);
                  wr_d      = IDX_W'(in_i.position);
                  left_d    = rm_moves;
                  state_d   = S_SHIFT;
                end
              end
            end
            psq_pkg::ACT_READOUT: begin
              if (!cnt_zero) begin
                out_load  = 1'b0;
                up_d      = in_i.front_first;
                rd_d      = read_start;
                mem_raddr = read_start;
                rd_wait_d = 1'b1;
                left_d    = count_q;
                state_d   = S_READ;
              end
            end
            default: begin
              // unused action code: fail, state kept
              ld_status = 1'b1;
            end
          endcase
        end
      end

      S_SHIFT: begin
        // write the entry read last cycle, fetch the next one
        mem_we    = 1'b1;
        mem_waddr = wr_q;
        mem_wdata = mem_rdata;
        if (left_q == CNT_W'(1)) begin
          state_d = ins_q ? S_PLACE : S_IDLE;
        end else begin
          mem_raddr = shift_nxt;
          rd_d      = shift_nxt;
          wr_d      = rd_q;
          left_d    = left_q - CNT_W'(1);
        end
      end

      S_PLACE: begin
        mem_we    = 1'b1;
        mem_waddr = pos_q;
        mem_wdata = val_q;
        state_d   = S_IDLE;
      end

      S_READ: begin
        if (rd_wait_q) begin
          // element arrives: load result register
          out_load    = 1'b1;
          ld_status   = 1'b0;
          ld_has_data = 1'b1;
          ld_data     = psq_pkg::VALUE_W'(mem_rdata);
          ld_last     = (left_q == CNT_W'(1));
          rd_wait_d   = 1'b0;
          left_d      = left_q - CNT_W'(1);
          rd_d        = up_q ? (rd_q + IDX_W'(1)) : (rd_q - IDX_W'(1));
          if (left_q == CNT_W'(1)) begin
            state_d = S_IDLE;
          end
        end else if (out_free) begin
          mem_raddr = rd_q;
          rd_wait_d = 1'b1;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      left_q      <= '0;
      rd_wait_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      left_q    <= left_d;
      rd_wait_q <= rd_wait_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    rd_q  <= rd_d;
    wr_q  <= wr_d;
    pos_q <= pos_d;
    val_q <= val_d;
    ins_q <= ins_d;
    up_q  <= up_d;
    if (out_load) begin
      out_status_q   <= ld_status;
      out_has_data_q <= ld_has_data;
      out_data_q     <= ld_data;
      out_last_q     <= ld_last;
    end
  end

  // result port
  assign out_o.valid    = out_valid_q;
  assign out_o.status   = out_status_q;
  assign out_o.has_data = out_has_data_q;
  assign out_o.data     = out_data_q;
  assign out_o.last     = out_last_q;

  // checks
  `ASSERT_AT(a_count_bound, clk_i, rst_ni, count_q <= CNT_W'(CAPACITY))
  `ASSERT_NEVER_AT(a_no_overwrite, clk_i, rst_ni, out_load && out_valid_q && !out_o.ready)
  `ASSERT_NEVER_AT(a_no_write_in_read, clk_i, rst_ni, (state_q == S_READ) && mem_we)
  `ASSERT_NEVER_AT(a_shift_nonzero, clk_i, rst_ni, (state_q == S_SHIFT) && (left_q == '0))

endmodule

// ===== tb/psq_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sequence store checker
// Watches the command and result channels, keeps its own copy of the list,
// predicts the results of every accepted command and compares them in order.
// ---------------------------------------------------------------------------
module psq_checker
  import psq_pkg::*;
#(
  parameter int CAPACITY = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  psq_in_if    cmd_mon,
  psq_out_if   res_mon,
  output int   mismatches_o,
  output int   outstanding_o
);

  localparam int PRINT_LIMIT = 40;

  typedef struct packed {
    logic                      status;
    logic                      has_data;
    logic signed [VALUE_W-1:0] data;
    logic                      last;
  } store_result_t;

  // list contents front to end, and results still owed by the block
  logic signed [VALUE_W-1:0] held_words[$];
  store_result_t             owed_results[$];
  int                        mismatch_count = 0;
  int                        result_index   = 0;

  assign mismatches_o = mismatch_count;

  initial outstanding_o = 0;

  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) begin
      $display("%0t ns: mismatch: %s", $time, what);
    end
  endtask

  // Apply one command to the local list and queue the results it causes
  task automatic apply_action(logic [ACT_W-1:0] act, logic signed [VALUE_W-1:0] word,
                              logic [POS_W-1:0] pos, logic front_first);
    int   n;
    int   idx;
    logic failed;
    n      = held_words.size();
    failed = 1'b1;
    case (act)
      ACT_APPEND: begin
        if (n < CAPACITY) begin
          held_words.push_back(word);
          failed = 1'b0;
        end
      end
      ACT_DROP: begin
        if (n > 0) begin
          void'(held_words.pop_back());
          failed = 1'b0;
        end
      end
      ACT_INSERT: begin
        if (n > 0 && int'(pos) < n && n < CAPACITY) begin
          held_words.insert(int'(pos), word);
          failed = 1'b0;
        end
      end
      ACT_REMOVE: begin
        if (n > 0 && int'(pos) < n) begin
          held_words.delete(int'(pos));
          failed = 1'b0;
        end
      end
      ACT_READOUT: begin
        // non-empty readout streams every word, last mark on the final one
        if (n > 0) begin
          for (int k = 0; k < n; k++) begin
            idx = front_first ? k : n - 1 - k;
            owed_results.push_back('{1'b0, 1'b1, held_words[idx], (k == n - 1)});
          end
          return;
        end
      end
      default: ;  // unused codes fail and keep the list
    endcase
    owed_results.push_back('{failed, 1'b0, '0, 1'b1});
  endtask

  // Commands first, so a result in the same cycle would still find its entry
  always @(posedge clk_i) begin : watch
    store_result_t got;
    store_result_t want;
    if (rst_ni) begin
      if (cmd_mon.valid && cmd_mon.ready) begin
        apply_action(cmd_mon.action, cmd_mon.value, cmd_mon.position, cmd_mon.front_first);
      end
      if (res_mon.valid && res_mon.ready) begin
        got = '{res_mon.status, res_mon.has_data, res_mon.data, res_mon.last};
        if (owed_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with none expected", result_index));
        end else begin
          want = owed_results.pop_front();
          if (got.status !== want.status)
            report_mismatch($sformatf("result %0d status %b, expected %b",
                                      result_index, got.status, want.status));
          if (got.has_data !== want.has_data)
            report_mismatch($sformatf("result %0d has_data %b, expected %b",
                                      result_index, got.has_data, want.has_data));
          if (got.data !== want.data)
            report_mismatch($sformatf("result %0d data %h, expected %h",
                                      result_index, got.data, want.data));
          if (got.last !== want.last)
            report_mismatch($sformatf("result %0d last %b, expected %b",
                                      result_index, got.last, want.last));
        end
        result_index++;
      end
    end
    outstanding_o <= owed_results.size();
  end

endmodule

// ===== tb/tb_positional_sequence_store_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sequence store testbench
// Directed corner commands, then random command streams steered toward a
// target fill level, under several sender and receiver stall patterns.
// ---------------------------------------------------------------------------
module tb_positional_sequence_store_core;
  import psq_pkg::*;

  localparam int STORE_DEPTH  = 32;
  localparam int RESET_CYCLES = 7;
  localparam int PHASE_ITEMS  = 100;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 100;
  localparam int CYCLE_LIMIT  = 500_000;

  localparam logic [ACT_W-1:0] ACT_UNUSED_FIRST = 3'd5;
  localparam logic [ACT_W-1:0] ACT_UNUSED_MID   = 3'd6;
  localparam logic [ACT_W-1:0] ACT_UNUSED_LAST  = 3'd7;

  localparam logic signed [VALUE_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VALUE_W-1:0] WORD_MIN = 32'sh8000_0000;

  logic clk_i;
  logic rst_ni;
  int   mismatches;
  int   results_outstanding;
  int   cycle_count        = 0;
  int   sender_idle_pct    = 0;
  int   receiver_stall_pct = 0;
  int   hold_requests      = 0;
  int   fill_level         = 0;
  int   fill_goal          = STORE_DEPTH;

  psq_in_if  cmd_if ();
  psq_out_if res_if ();

  positional_sequence_store_core #(
    .CAPACITY  (STORE_DEPTH),
    .DATA_WIDTH(VALUE_W)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (cmd_if),
    .out_o (res_if)
  );

  psq_checker #(
    .CAPACITY(STORE_DEPTH)
  ) checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_mon      (cmd_if),
    .res_mon      (res_if),
    .mismatches_o (mismatches),
    .outstanding_o(results_outstanding)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result receiver: random stalls, plus long hold-offs on request
  initial begin : receiver
    int hold_left;
    int holds_seen;
    hold_left    = 0;
    holds_seen   = 0;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_requests != holds_seen) begin
        holds_seen = hold_requests;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  // Fill level the command will leave, used only to steer stimulus
  function automatic int next_fill(logic [ACT_W-1:0] act, logic [POS_W-1:0] pos, int n);
    case (act)
      ACT_APPEND: return (n < STORE_DEPTH) ? n + 1 : n;
      ACT_DROP:   return (n > 0) ? n - 1 : n;
      ACT_INSERT: return (n > 0 && int'(pos) < n && n < STORE_DEPTH) ? n + 1 : n;
      ACT_REMOVE: return (n > 0 && int'(pos) < n) ? n - 1 : n;
      default:    return n;
    endcase
  endfunction

  // Offer one command, with random idle cycles ahead of it, until taken
  task automatic send_item(logic [ACT_W-1:0] act, logic signed [VALUE_W-1:0] word,
                           logic [POS_W-1:0] pos, logic front_first);
    while ($urandom_range(99) < sender_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_if.valid       <= 1'b1;
    cmd_if.action      <= act;
    cmd_if.value       <= word;
    cmd_if.position    <= pos;
    cmd_if.front_first <= front_first;
    do @(posedge clk_i); while (!cmd_if.ready);
    fill_level = next_fill(act, pos, fill_level);
  endtask

  // Sender pause until every owed result has come back
  task automatic wait_for_results();
    cmd_if.valid <= 1'b0;
    do @(posedge clk_i); while (results_outstanding != 0);
  endtask

  // One random command, biased toward the current fill goal
  task automatic random_item(int item_no);
    int                        r;
    logic [ACT_W-1:0]          act;
    logic [POS_W-1:0]          pos;
    logic signed [VALUE_W-1:0] word;
    if (item_no % 30 == 0) begin
      r = $urandom_range(3);
      fill_goal = (r == 0) ? 0 : (r == 1) ? STORE_DEPTH : $urandom_range(STORE_DEPTH - 1, 1);
    end
    r = $urandom_range(99);
    if (fill_level < fill_goal) begin
      if (r < 35)      act = ACT_APPEND;
      else if (r < 65) act = ACT_INSERT;
      else if (r < 75) act = ACT_REMOVE;
      else if (r < 80) act = ACT_DROP;
      else if (r < 96) act = ACT_READOUT;
      else             act = 3'($urandom_range(ACT_UNUSED_LAST, ACT_UNUSED_FIRST));
    end else if (fill_level > fill_goal) begin
      if (r < 10)      act = ACT_APPEND;
      else if (r < 20) act = ACT_INSERT;
      else if (r < 55) act = ACT_REMOVE;
      else if (r < 80) act = ACT_DROP;
      else if (r < 96) act = ACT_READOUT;
      else             act = 3'($urandom_range(ACT_UNUSED_LAST, ACT_UNUSED_FIRST));
    end else begin
      // at the goal: a mix, which fails appends when full and drops when empty
      if (r < 20)      act = ACT_APPEND;
      else if (r < 40) act = ACT_INSERT;
      else if (r < 60) act = ACT_REMOVE;
      else if (r < 75) act = ACT_DROP;
      else if (r < 95) act = ACT_READOUT;
      else             act = 3'($urandom_range(ACT_UNUSED_LAST, ACT_UNUSED_FIRST));
    end
    if ($urandom_range(99) < 85 && fill_level > 0) pos = POS_W'($urandom_range(fill_level - 1));
    else                                           pos = POS_W'($urandom_range(31));
    r = $urandom_range(99);
    if (r < 3)       word = WORD_MAX;
    else if (r < 6)  word = WORD_MIN;
    else if (r < 8)  word = '0;
    else if (r < 10) word = '1;
    else             word = $urandom;
    send_item(act, word, pos, 1'($urandom_range(1)));
  endtask

  // Stimulus and verdict
  initial begin
    cmd_if.valid       = 1'b0;
    cmd_if.action      = ACT_APPEND;
    cmd_if.value       = '0;
    cmd_if.position    = '0;
    cmd_if.front_first = 1'b0;
    rst_ni             = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list corners
    send_item(ACT_READOUT, '0, 0, 1'b1);
    send_item(ACT_DROP, '0, 0, 1'b0);
    send_item(ACT_INSERT, 32'sd5, 0, 1'b0);
    send_item(ACT_REMOVE, '0, 0, 1'b0);
    // remove the only element, then read out the emptied list
    send_item(ACT_APPEND, 32'sd7, 0, 1'b0);
    send_item(ACT_REMOVE, '0, 0, 1'b0);
    send_item(ACT_READOUT, '0, 0, 1'b0);
    // value extremes
    send_item(ACT_APPEND, WORD_MAX, 0, 1'b0);
    send_item(ACT_APPEND, WORD_MIN, 0, 1'b0);
    send_item(ACT_APPEND, '0, 0, 1'b0);
    send_item(ACT_APPEND, '1, 0, 1'b0);
    // insert at and past the count fails; at front and before last works
    send_item(ACT_INSERT, 32'sd1, 4, 1'b0);
    send_item(ACT_INSERT, 32'sd2, 31, 1'b0);
    send_item(ACT_INSERT, 32'sh5555_5555, 0, 1'b0);
    send_item(ACT_INSERT, 32'shAAAA_AAAA, 4, 1'b0);
    // remove past the end fails, removing the last element works
    send_item(ACT_REMOVE, '0, 6, 1'b0);
    send_item(ACT_REMOVE, '0, 5, 1'b0);
    send_item(ACT_READOUT, '0, 0, 1'b1);
    send_item(ACT_READOUT, '0, 0, 1'b0);
    // unused action codes
    send_item(ACT_UNUSED_FIRST, 32'sd9, 0, 1'b0);
    send_item(ACT_UNUSED_MID, 32'sd9, 1, 1'b1);
    send_item(ACT_UNUSED_LAST, 32'sd9, 2, 1'b0);
    send_item(ACT_DROP, '0, 0, 1'b0);
    send_item(ACT_REMOVE, '0, 31, 1'b0);
    send_item(ACT_READOUT, '0, 0, 1'b0);
    wait_for_results();

    // random phases: no idling, sender idle, receiver stall, both
    for (int phase = 0; phase < 4; phase++) begin
      sender_idle_pct    = (phase == 1) ? 60 : (phase == 3) ? 25 : 0;
      receiver_stall_pct <= (phase == 2) ? 60 : (phase == 3) ? 25 : 0;
      for (int i = 0; i < PHASE_ITEMS; i++) random_item(i);
      wait_for_results();
    end

    // long receiver hold-off while the sender keeps offering
    sender_idle_pct    = 0;
    receiver_stall_pct <= 0;
    hold_requests      <= hold_requests + 1;
    for (int i = 0; i < PHASE_ITEMS; i++) random_item(i);
    wait_for_results();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && results_outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/psq_pkg.sv
hdl/psq_ifs.sv
hdl/psq_ram.sv
hdl/positional_sequence_store_core.sv
tb/psq_checker.sv
tb/tb_positional_sequence_store_core.sv
